>>> design/double_ended_priority_queue_assert.svh
// Assertion macros for the double-ended priority queue.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define DEPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/depq_pkg.sv
// Shared types and constants for the double-ended priority queue.
`default_nettype none

package depq_pkg;

    localparam int DEPQ_CAPACITY = 16;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MIN = 2'd1,
        OP_DEL_MAX = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic signed [15:0] prio;
        logic signed [15:0] temp;
    } entry_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] priority_req;
        logic signed [15:0] temperature;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [15:0]       removed_priority;
        logic signed [15:0]       removed_temperature;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic signed [15:0]       max_priority;
        logic signed [15:0]       max_temperature;
        logic signed [15:0]       min_priority;
        logic signed [15:0]       min_temperature;
    } out_item_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   en;
        op_t    op;
        entry_t item;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/double_ended_priority_queue.sv
// Top level of the double-ended priority queue built as a chain of sorting cells.
`default_nettype none
`include "double_ended_priority_queue_assert.svh"

// Holds up to CAPACITY (priority, temperature) pairs in descending priority
// order, one pair per cell, head in cell 0. In the accept cycle every cell
// updates at once from its own compare and its neighbors (insert shifts toward
// the tail, delete-max toward the head); then, in S_REPORT, once the result
// register can take it, the tail cell is selected by the count and the result
// is registered. No new item is taken until that result is loaded; one
// finished result may wait in the result register. Storage needs no
// clearing after reset: only cells below the count are ever reported.
module double_ended_priority_queue #(
    parameter int CAPACITY = depq_pkg::DEPQ_CAPACITY
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire depq_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output depq_pkg::out_item_t      rsp
);
    import depq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    status_t           status_reg;
    entry_t            removed_reg;
    out_item_t         rsp_reg;
    logic              rsp_valid_reg;

    entry_t            cell_entry [CAPACITY];
    logic              cell_gt    [CAPACITY];
    cell_cmd_t         cmd;

    logic              accept;
    logic              load;
    logic              fail_full;
    logic              fail_empty;
    logic [CNT_W-1:0]  tail_pos;
    logic [IDX_W-1:0]  tail_idx;
    entry_t            tail_entry;
    entry_t            removed_sel;

    assign accept     = req_valid && !req_stall;
    assign fail_full  = (req.op == OP_INSERT) && (count_reg == CNT_W'(CAPACITY));
    assign fail_empty = ((req.op == OP_DEL_MIN) || (req.op == OP_DEL_MAX)) &&
                        (count_reg == '0);
    assign tail_pos   = count_reg - CNT_W'(1);
    assign tail_idx   = tail_pos[IDX_W-1:0];
    assign tail_entry = cell_entry[tail_idx];

    assign cmd.en        = accept && !fail_full && !fail_empty;
    assign cmd.op        = req.op;
    assign cmd.item.prio = req.priority_req;
    assign cmd.item.temp = req.temperature;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_g;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_e = cmd.item;
                assign left_g = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_g = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            depq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.en)
        begin
            case (req.op)
                OP_INSERT:                  count_next = count_reg + CNT_W'(1);
                OP_DEL_MIN, OP_DEL_MAX:     count_next = count_reg - CNT_W'(1);
                default:                    count_next = count_reg;
            endcase
        end
    end

    always_comb
    begin
        removed_sel = '0;
        if (cmd.en)
        begin
            case (req.op)
                OP_DEL_MIN: removed_sel = tail_entry;
                OP_DEL_MAX: removed_sel = cell_entry[0];
                default:    removed_sel = '0;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_REPORT;
            S_REPORT: if (load)   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req_stall = 1'b1;
        load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_REPORT:
            begin
                load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= fail_full ? ST_FULL : (fail_empty ? ST_EMPTY : ST_OK);
            removed_reg <= removed_sel;
        end
        if (load)
        begin
            rsp_reg.status              <= status_reg;
            rsp_reg.removed_priority    <= removed_reg.prio;
            rsp_reg.removed_temperature <= removed_reg.temp;
            rsp_reg.entry_count         <= COUNT_OUT_W'(count_reg);
            if (count_reg == '0)
            begin
                rsp_reg.max_priority    <= '0;
                rsp_reg.max_temperature <= '0;
                rsp_reg.min_priority    <= '0;
                rsp_reg.min_temperature <= '0;
            end
            else
            begin
                rsp_reg.max_priority    <= cell_entry[0].prio;
                rsp_reg.max_temperature <= cell_entry[0].temp;
                rsp_reg.min_priority    <= tail_entry.prio;
                rsp_reg.min_temperature <= tail_entry.temp;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DEPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `DEPQ_ASSERT(a_full_holds, clk, rst_n, accept && fail_full |=> $stable(count_reg), "full insert changed count")
    `DEPQ_ASSERT(a_insert_inc, clk, rst_n, cmd.en && (req.op == OP_INSERT) |=> count_reg == $past(count_reg) + CNT_W'(1), "insert did not add one")
    `DEPQ_ASSERT(a_accept_report, clk, rst_n, accept |=> state_reg == S_REPORT, "accept without report")
    `DEPQ_ASSERT(a_rsp_source, clk, rst_n, $rose(rsp_valid_reg) |-> $past(state_reg == S_REPORT), "result without item")

endmodule

`default_nettype wire

>>> design/depq_cell.sv
// One position of the sorted chain: holds a pair, shifts toward head or tail.
`default_nettype none

module depq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                clk,
    input  wire depq_pkg::cell_cmd_t cmd,
    input  wire logic [CNT_W-1:0]    count,
    input  wire depq_pkg::entry_t    left_entry,
    input  wire logic                left_gt,
    input  wire depq_pkg::entry_t    right_entry,
    output depq_pkg::entry_t         entry,
    output logic                     gt
);
    import depq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Live and strictly greater than the incoming priority: stays in place.
    assign gt    = (CNT_W'(INDEX) < count) &&
                   ($signed(entry_reg.prio) > $signed(cmd.item.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                OP_INSERT:
                begin
                    if (!gt)
                    begin
                        entry_next = left_gt ? cmd.item : left_entry;
                    end
                end
                OP_DEL_MAX:
                begin
                    entry_next = right_entry;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire
